>>> rtl/core/pse_pkg.sv
// Shared types, codes and reset constants of the particle swarm sphere engine.
// Used by pse_ctrl, pse_datapath and particle_swarm_sphere_engine.
package pse_pkg;

  localparam int PSE_DIMENSIONS = 32;
  localparam int PSE_PARTICLES  = 128;

  localparam int OP_W        = 3;
  localparam int PART_W      = 7;
  localparam int DIM_W       = 5;
  localparam int VAL_W       = 32;
  localparam int RAND_W      = 16;
  localparam int GAIN_W      = 16;
  localparam int FIT_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 104;

  localparam logic [GAIN_W-1:0] INERTIA_RST   = 16'd9830;
  localparam logic [GAIN_W-1:0] COGNITIVE_RST = 16'd26214;
  localparam logic [GAIN_W-1:0] SOCIAL_RST    = 16'd26214;
  localparam logic [VAL_W-1:0]  CENTER_RST    = 32'd65536;
  localparam logic [FIT_W-1:0]  INIT_FIT_RST  = 64'd429492434632704;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_POS = 3'd0,
    OP_LOAD_VEL = 3'd1,
    OP_LOAD_GB  = 3'd2,
    OP_EVAL     = 3'd3,
    OP_MOVE     = 3'd4,
    OP_READ_GB  = 3'd5,
    OP_CLEAR    = 3'd6
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INERTIA   = 3'd0,
    CFG_COGNITIVE = 3'd1,
    CFG_SOCIAL    = 3'd2,
    CFG_CENTER    = 3'd3,
    CFG_INIT_FIT  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SRC_GB  = 2'd0,
    SRC_POS = 2'd1,
    SRC_PB  = 2'd2
  } src_t;

  typedef struct packed {
    logic ld_pos;
    logic ld_vel;
    logic ld_gb;
    logic mv_wr;
    logic walk;
    src_t src;
    logic acc_clr;
    logic copy_pb;
    logic copy_gb;
    logic sweep_wr;
    logic sweep_pbf;
    logic pbf_upd;
    logic fit_latch;
    logic gbf_load;
    logic changed_set;
    logic res_clr;
    logic elem_rd;
    logic res_out;
  } pse_cmd_t;

  typedef struct packed {
    logic busy;
    logic lower;
    logic adopt;
  } pse_status_t;

endpackage

>>> rtl/core/pse_datapath.sv
// Datapath: position, velocity and best stores, sphere accumulator, move arithmetic.
// Driven by pse_ctrl through pse_pkg command and status structs.
module pse_datapath #(
  parameter int DIMENSIONS = pse_pkg::PSE_DIMENSIONS,
  parameter int PARTICLES  = pse_pkg::PSE_PARTICLES,
  parameter int CELLS      = PARTICLES * DIMENSIONS,
  parameter int AW         = (CELLS > 1) ? $clog2(CELLS) : 1,
  parameter int DW         = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1,
  parameter int PW         = (PARTICLES > 1) ? $clog2(PARTICLES) : 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pse_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  pse_pkg::pse_cmd_t                cmd,
  input  logic [pse_pkg::VAL_W-1:0]        value,
  input  logic [pse_pkg::RAND_W-1:0]       rand_cognitive,
  input  logic [pse_pkg::RAND_W-1:0]       rand_social,
  input  logic [AW-1:0]                    cell_addr,
  input  logic [DW-1:0]                    gb_addr,
  input  logic [PW-1:0]                    pbf_addr,
  output pse_pkg::pse_status_t             status,
  output logic [pse_pkg::FIT_W-1:0]        global_fitness,
  output logic [pse_pkg::VAL_W-1:0]        element_value,
  output logic                             best_changed
);
  import pse_pkg::*;

  logic [GAIN_W-1:0] inertia_weight, cognitive_gain, social_gain;
  logic [VAL_W-1:0]  sphere_center;
  logic [FIT_W-1:0]  initial_best_fitness;

  logic [VAL_W-1:0] pos_mem [CELLS];
  logic [VAL_W-1:0] vel_mem [CELLS];
  logic [VAL_W-1:0] pb_mem  [CELLS];
  logic [FIT_W-1:0] pbf_mem [PARTICLES];
  logic [VAL_W-1:0] gb_mem  [DIMENSIONS];

  logic [VAL_W-1:0] pos_rdata, vel_rdata, pb_rdata, gb_rdata;
  logic [FIT_W-1:0] pbf_rdata;

  logic [FIT_W-1:0] gbf, bestfit, acc;
  logic             walk_d1, v2, v3, cpb_d1, cgb_d1;
  src_t             src_d1;
  logic [AW-1:0]    cell_d1;
  logic [DW-1:0]    gb_d1;
  logic [31:0]      mag;
  logic [63:0]      sq;

  logic [VAL_W-1:0] sel_data;
  logic [32:0]      diff, diff_neg;
  logic [31:0]      mag_next;
  logic [64:0]      acc_sum;

  logic [31:0]        kp_prod, kg_prod;
  logic [15:0]        kp_a, kg_a;
  logic signed [32:0] dpb_a, dgb_a;
  logic signed [31:0] v_a, x_a, x_b, x_c, nv_c;
  logic signed [48:0] p0_b;
  logic signed [49:0] p1_b, p2_b;
  logic signed [51:0] s_sum, s_sh;
  logic signed [31:0] nv_next, np;
  logic [32:0]        np_sum;

  logic             pos_we, vel_we, pb_we, gb_we, pbf_we;
  logic [VAL_W-1:0] pos_wdata, vel_wdata, pb_wdata, gb_wdata;
  logic [FIT_W-1:0] pbf_wdata;
  logic [AW-1:0]    pb_waddr;
  logic [DW-1:0]    gb_waddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      inertia_weight       <= INERTIA_RST;
      cognitive_gain       <= COGNITIVE_RST;
      social_gain          <= SOCIAL_RST;
      sphere_center        <= CENTER_RST;
      initial_best_fitness <= INIT_FIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INERTIA:   inertia_weight       <= cfg_data[GAIN_W-1:0];
        CFG_COGNITIVE: cognitive_gain       <= cfg_data[GAIN_W-1:0];
        CFG_SOCIAL:    social_gain          <= cfg_data[GAIN_W-1:0];
        CFG_CENTER:    sphere_center        <= cfg_data[VAL_W-1:0];
        CFG_INIT_FIT:  initial_best_fitness <= cfg_data;
        default: ;
      endcase
    end
  end

  // store write selection
  always_comb begin
    pos_we    = cmd.ld_pos | cmd.mv_wr;
    pos_wdata = cmd.mv_wr ? np : value;
    vel_we    = cmd.ld_vel | cmd.mv_wr;
    vel_wdata = cmd.mv_wr ? nv_c : value;
    pb_we     = cmd.sweep_wr | cpb_d1;
    pb_waddr  = cpb_d1 ? cell_d1 : cell_addr;
    pb_wdata  = cpb_d1 ? pos_rdata : '0;
    gb_we     = cmd.ld_gb | cgb_d1;
    gb_waddr  = cgb_d1 ? gb_d1 : gb_addr;
    gb_wdata  = cgb_d1 ? pb_rdata : value;
    pbf_we    = cmd.sweep_pbf | cmd.pbf_upd;
    pbf_wdata = cmd.pbf_upd ? acc : initial_best_fitness;
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[cell_addr] <= pos_wdata;
    pos_rdata <= pos_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (vel_we) vel_mem[cell_addr] <= vel_wdata;
    vel_rdata <= vel_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (pb_we) pb_mem[pb_waddr] <= pb_wdata;
    pb_rdata <= pb_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (gb_we) gb_mem[gb_waddr] <= gb_wdata;
    gb_rdata <= gb_mem[gb_addr];
  end

  always_ff @(posedge clk) begin
    if (pbf_we) pbf_mem[pbf_addr] <= pbf_wdata;
    pbf_rdata <= pbf_mem[pbf_addr];
  end

  // sphere accumulator
  always_comb begin
    case (src_d1)
      SRC_GB:  sel_data = gb_rdata;
      SRC_POS: sel_data = pos_rdata;
      SRC_PB:  sel_data = pb_rdata;
      default: sel_data = gb_rdata;
    endcase
    diff     = {sel_data[31], sel_data} - {sphere_center[31], sphere_center};
    diff_neg = -diff;
    mag_next = diff[32] ? diff_neg[31:0] : diff[31:0];
    acc_sum  = {1'b0, acc} + {1'b0, sq};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_d1      <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      cpb_d1       <= 1'b0;
      cgb_d1       <= 1'b0;
      gbf          <= '1;
      element_value <= '0;
      best_changed <= 1'b0;
    end else begin
      walk_d1 <= cmd.walk;
      v2      <= walk_d1;
      v3      <= v2;
      cpb_d1  <= cmd.copy_pb;
      cgb_d1  <= cmd.copy_gb;
      if (cmd.gbf_load) gbf <= acc;
      if (cmd.res_clr) element_value <= '0;
      else if (cmd.elem_rd) element_value <= gb_rdata;
      else if (cmd.mv_wr) element_value <= np;
      if (cmd.res_clr) best_changed <= 1'b0;
      else if (cmd.changed_set) best_changed <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    src_d1  <= cmd.src;
    cell_d1 <= cell_addr;
    gb_d1   <= gb_addr;
    mag     <= mag_next;
    sq      <= mag * mag;
    if (cmd.acc_clr) acc <= '0;
    else if (v3) acc <= acc_sum[64] ? '1 : acc_sum[63:0];
    if (cmd.fit_latch) bestfit <= status.lower ? acc : pbf_rdata;
  end

  // move pipeline: operands, products, velocity, position
  always_comb begin
    kp_prod = cognitive_gain * rand_cognitive;
    kg_prod = social_gain * rand_social;
    s_sum   = {{3{p0_b[48]}}, p0_b} + {{2{p1_b[49]}}, p1_b} + {{2{p2_b[49]}}, p2_b};
    s_sh    = s_sum >>> 14;
    if ((&s_sh[51:31]) | ~(|s_sh[51:31])) nv_next = s_sh[31:0];
    else nv_next = s_sh[51] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    np_sum  = {x_c[31], x_c} + {nv_c[31], nv_c};
    if (np_sum[32] != np_sum[31]) np = np_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else np = np_sum[31:0];
  end

  always_ff @(posedge clk) begin
    kp_a  <= kp_prod[31:16];
    kg_a  <= kg_prod[31:16];
    dpb_a <= {pb_rdata[31], pb_rdata} - {pos_rdata[31], pos_rdata};
    dgb_a <= {gb_rdata[31], gb_rdata} - {pos_rdata[31], pos_rdata};
    v_a   <= vel_rdata;
    x_a   <= pos_rdata;
    p0_b  <= $signed({1'b0, inertia_weight}) * v_a;
    p1_b  <= $signed({1'b0, kp_a}) * dpb_a;
    p2_b  <= $signed({1'b0, kg_a}) * dgb_a;
    x_b   <= x_a;
    nv_c  <= nv_next;
    x_c   <= x_b;
  end

  assign status.busy     = walk_d1 | v2 | v3 | cpb_d1 | cgb_d1;
  assign status.lower    = acc < pbf_rdata;
  assign status.adopt    = bestfit < gbf;
  assign global_fitness  = gbf;

  a_gbf_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.gbf_load |-> !status.busy)
    else $error("global fitness loaded before accumulator drained");
  a_pbf_lower: assert property (@(posedge clk) disable iff (rst)
    cmd.pbf_upd |-> status.lower && !status.busy)
    else $error("personal best fitness replaced without lower score");
  a_pb_port: assert property (@(posedge clk) disable iff (rst)
    cpb_d1 |-> !cmd.sweep_wr)
    else $error("personal best copy collides with clearing sweep");
  a_gb_port: assert property (@(posedge clk) disable iff (rst)
    cgb_d1 |-> !cmd.ld_gb)
    else $error("global best copy collides with load");

endmodule

>>> rtl/core/pse_ctrl.sv
// Controller: item dispatch, clearing sweep and evaluate walk sequencing.
// Drives pse_datapath through pse_pkg command and status structs.
module pse_ctrl #(
  parameter int DIMENSIONS = pse_pkg::PSE_DIMENSIONS,
  parameter int PARTICLES  = pse_pkg::PSE_PARTICLES,
  parameter int CELLS      = PARTICLES * DIMENSIONS,
  parameter int AW         = (CELLS > 1) ? $clog2(CELLS) : 1,
  parameter int DW         = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1,
  parameter int PW         = (PARTICLES > 1) ? $clog2(PARTICLES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        out_free,
  input  pse_pkg::op_t                op,
  input  logic [pse_pkg::PART_W-1:0]  particle,
  input  logic [pse_pkg::DIM_W-1:0]   dimension,
  input  pse_pkg::pse_status_t        status,
  output pse_pkg::pse_cmd_t           cmd,
  output logic [AW-1:0]               cell_addr,
  output logic [DW-1:0]               gb_addr,
  output logic [PW-1:0]               pbf_addr
);
  import pse_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_MV0, S_MV1, S_MV2, S_MV3, S_MV4,
    S_RD0, S_RD1, S_EV_GB, S_EV_GBW, S_SC, S_SCW, S_CP, S_CPW,
    S_CHK, S_AD, S_ADW, S_DONE
  } state_t;

  state_t        state;
  logic [DW-1:0] dcnt;
  logic [PW-1:0] pidx;
  logic [AW-1:0] row;
  logic [AW-1:0] cnt;
  logic          sweep_item;

  logic          part_ok, dim_ok, inr, dlast, plast, walking;
  logic [AW-1:0] item_cell;

  always_comb begin
    part_ok   = 32'(particle) < PARTICLES;
    dim_ok    = 32'(dimension) < DIMENSIONS;
    inr       = part_ok & dim_ok;
    item_cell = AW'(AW'(particle) * AW'(DIMENSIONS) + AW'(dimension));
    dlast     = dcnt == DW'(DIMENSIONS - 1);
    plast     = pidx == PW'(PARTICLES - 1);
    walking   = (state == S_SC) || (state == S_CP) || (state == S_AD);
  end

  always_comb begin
    cmd       = '0;
    cmd.src   = SRC_GB;
    in_ready  = state == S_IDLE;
    cell_addr = walking ? AW'(row + AW'(dcnt)) : (state == S_CLEAR) ? cnt : item_cell;
    gb_addr   = ((state == S_EV_GB) || (state == S_AD)) ? dcnt : DW'(dimension);
    pbf_addr  = (state == S_CLEAR) ? cnt[PW-1:0] : pidx;
    case (state)
      S_CLEAR: begin
        cmd.sweep_wr  = 1'b1;
        cmd.sweep_pbf = {1'b0, cnt} < (AW+1)'(PARTICLES);
      end
      S_DISPATCH: begin
        cmd.res_clr = 1'b1;
        cmd.ld_pos  = (op == OP_LOAD_POS) && inr;
        cmd.ld_vel  = (op == OP_LOAD_VEL) && inr;
        cmd.ld_gb   = (op == OP_LOAD_GB) && inr;
      end
      S_MV4: cmd.mv_wr = 1'b1;
      S_RD1: cmd.elem_rd = 1'b1;
      S_EV_GB: begin
        cmd.walk    = 1'b1;
        cmd.src     = SRC_GB;
        cmd.acc_clr = dcnt == '0;
      end
      S_EV_GBW: cmd.gbf_load = !status.busy;
      S_SC: begin
        cmd.walk    = 1'b1;
        cmd.src     = SRC_POS;
        cmd.acc_clr = dcnt == '0;
      end
      S_SCW: begin
        cmd.src       = SRC_POS;
        cmd.fit_latch = !status.busy;
        cmd.pbf_upd   = !status.busy && status.lower;
      end
      S_CP: cmd.copy_pb = 1'b1;
      S_AD: begin
        cmd.walk    = 1'b1;
        cmd.src     = SRC_PB;
        cmd.copy_gb = 1'b1;
        cmd.acc_clr = dcnt == '0;
      end
      S_ADW: begin
        cmd.src         = SRC_PB;
        cmd.gbf_load    = !status.busy;
        cmd.changed_set = !status.busy;
      end
      S_DONE: cmd.res_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      dcnt       <= '0;
      pidx       <= '0;
      row        <= '0;
      sweep_item <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          cnt <= AW'(cnt + 1'b1);
          if (cnt == AW'(CELLS - 1)) begin
            state <= sweep_item ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          dcnt <= '0;
          case (op)
            OP_EVAL:    state <= S_EV_GB;
            OP_MOVE:    state <= inr ? S_MV0 : S_DONE;
            OP_READ_GB: state <= dim_ok ? S_RD0 : S_DONE;
            OP_CLEAR: begin
              cnt        <= '0;
              sweep_item <= 1'b1;
              state      <= S_CLEAR;
            end
            default:    state <= S_DONE;
          endcase
        end
        S_MV0: state <= S_MV1;
        S_MV1: state <= S_MV2;
        S_MV2: state <= S_MV3;
        S_MV3: state <= S_MV4;
        S_MV4: state <= S_DONE;
        S_RD0: state <= S_RD1;
        S_RD1: state <= S_DONE;
        S_EV_GB, S_SC, S_CP, S_AD: begin
          dcnt <= DW'(dcnt + 1'b1);
          if (dlast) begin
            dcnt <= '0;
            case (state)
              S_EV_GB: state <= S_EV_GBW;
              S_SC:    state <= S_SCW;
              S_CP:    state <= S_CPW;
              default: state <= S_ADW;
            endcase
          end
        end
        S_EV_GBW: begin
          if (!status.busy) begin
            pidx  <= '0;
            row   <= '0;
            state <= S_SC;
          end
        end
        S_SCW: begin
          if (!status.busy) state <= status.lower ? S_CP : S_CHK;
        end
        S_CPW: begin
          if (!status.busy) state <= S_CHK;
        end
        S_CHK, S_ADW: begin
          if (state == S_CHK && status.adopt) begin
            state <= S_AD;
          end else if (state == S_CHK || !status.busy) begin
            if (plast) begin
              state <= S_DONE;
            end else begin
              pidx  <= PW'(pidx + 1'b1);
              row   <= AW'(row + AW'(DIMENSIONS));
              state <= S_SC;
            end
          end
        end
        S_DONE: begin
          sweep_item <= 1'b0;
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_after_out: assert property (@(posedge clk) disable iff (rst)
    cmd.res_out |=> in_ready)
    else $error("block not ready after delivering a result");
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_wr |-> !in_ready)
    else $error("item accepted during clearing sweep");
  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (walking && dlast) |=> !walking || dcnt == '0)
    else $error("walk counter did not wrap at row end");

endmodule

>>> rtl/core/particle_swarm_sphere_engine.sv
// Particle swarm optimizer core, sphere fitness; top level over pse_ctrl and pse_datapath.
// Items load positions, velocities or global best elements, move a particle, read the
// global best, clear the personal bests or evaluate the swarm; evaluation copies each improved
// particle to its personal best and adopts a personal best that beats the global best.
// One item at a time; the next item is taken while the previous result waits at the output.
// Reset is synchronous; after it the personal best stores are cleared before the first item is taken.
module particle_swarm_sphere_engine #(
  parameter int DIMENSIONS = pse_pkg::PSE_DIMENSIONS,
  parameter int PARTICLES  = pse_pkg::PSE_PARTICLES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // operation, particle, dimension, value, rand_cognitive, rand_social
  input  logic [pse_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // global_fitness, element_value, best_changed
  output logic [pse_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [pse_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pse_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pse_pkg::*;

  localparam int CELLS = PARTICLES * DIMENSIONS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DW    = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int PW    = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

  op_t               op;
  logic [PART_W-1:0] particle;
  logic [DIM_W-1:0]  dimension;
  logic [VAL_W-1:0]  value;
  logic [RAND_W-1:0] rand_cognitive, rand_social;

  pse_cmd_t          cmd;
  pse_status_t       status;
  logic [AW-1:0]     cell_addr;
  logic [DW-1:0]     gb_addr;
  logic [PW-1:0]     pbf_addr;
  logic [FIT_W-1:0]  global_fitness;
  logic [VAL_W-1:0]  element_value;
  logic              best_changed;

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op             <= op_t'(s_axis_tdata[2:0]);
      particle       <= s_axis_tdata[9:3];
      dimension      <= s_axis_tdata[14:10];
      value          <= s_axis_tdata[46:15];
      rand_cognitive <= s_axis_tdata[62:47];
      rand_social    <= s_axis_tdata[78:63];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.res_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_out) begin
      m_axis_tdata <= {7'd0, best_changed, element_value, global_fitness};
    end
  end

  pse_ctrl #(
    .DIMENSIONS(DIMENSIONS),
    .PARTICLES (PARTICLES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (!m_axis_tvalid || m_axis_tready),
    .op       (op),
    .particle (particle),
    .dimension(dimension),
    .status   (status),
    .cmd      (cmd),
    .cell_addr(cell_addr),
    .gb_addr  (gb_addr),
    .pbf_addr (pbf_addr)
  );

  pse_datapath #(
    .DIMENSIONS(DIMENSIONS),
    .PARTICLES (PARTICLES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .value         (value),
    .rand_cognitive(rand_cognitive),
    .rand_social   (rand_social),
    .cell_addr     (cell_addr),
    .gb_addr       (gb_addr),
    .pbf_addr      (pbf_addr),
    .status        (status),
    .global_fitness(global_fitness),
    .element_value (element_value),
    .best_changed  (best_changed)
  );

endmodule
